// File: rtl/core/bilinear_pixel_sampler_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear pixel sampler
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_PIXEL_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BPS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bps_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear pixel sampler package
// Widths, codes, payload types and controller types shared by the block.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Store geometry and fixed-point format.
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned ADDR_W     = ROW_W + COL_W;
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Field widths.
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned RGB_W   = 3 * PIX_W;
    localparam int unsigned COORD_W = 20;
    localparam int unsigned INT_W   = COORD_W - 1 - FRAC_BITS;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned CFG_IDX_W = 1;

    // Blend arithmetic widths.
    localparam int unsigned WGT_W = FRAC_BITS + 1;
    localparam int unsigned H_W   = PIX_W + FRAC_BITS;
    localparam int unsigned V_W   = PIX_W + 2 * FRAC_BITS;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Input item.
    typedef struct packed {
        logic                      command;
        logic [COL_W-1:0]          pixel_col;
        logic [ROW_W-1:0]          pixel_row;
        logic [PIX_W-1:0]          pixel_blue;
        logic [PIX_W-1:0]          pixel_green;
        logic [PIX_W-1:0]          pixel_red;
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
    } bps_item_t;

    // Result item.
    typedef struct packed {
        logic             in_bounds;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
    } bps_result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_HORZ,
        ST_VERT,
        ST_OUT
    } bps_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       pixel_write;
        logic       sample_load;
        logic       bounds_load;
        logic       rd_en;
        logic       horz_en;
        logic       vert_en;
        logic       out_load;
        logic [1:0] idx;
    } bps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_bounds;
    } bps_status_t;

    // One channel out of a packed three-channel pixel.
    function automatic logic [PIX_W-1:0] chan_of(input logic [RGB_W-1:0] pix,
                                                 input logic [1:0] sel);
        logic [PIX_W-1:0] c;
        case (sel)
            2'd0:    c = pix[0 +: PIX_W];
            2'd1:    c = pix[PIX_W +: PIX_W];
            2'd2:    c = pix[2 * PIX_W +: PIX_W];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/bps_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one write or sample item.
// ----------------------------------------------------------------------------
interface bps_item_if;

    logic              valid;
    logic              ready;
    bps_pkg::bps_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/core/bps_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one interpolated sample.
// ----------------------------------------------------------------------------
interface bps_result_if;

    logic                valid;
    logic                ready;
    bps_pkg::bps_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/core/bps_ctrl.sv
// ----------------------------------------------------------------------------
// Bilinear sampler controller
// Sequences bounds check, four neighbor reads, channel blends and output.
// ----------------------------------------------------------------------------
module bps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_command,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    output bps_pkg::bps_cmd_t     cmd,
    input  bps_pkg::bps_status_t  status
);

    bps_pkg::bps_state_t state_reg, state_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // State, counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bps_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        item_ready = 1'b0;

        // A waiting result leaves once the sink takes it.
        out_valid_next = out_valid_reg && !result_ready;

        case (state_reg)
            bps_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_command == bps_pkg::CMD_SAMPLE)
                    begin
                        cmd.sample_load = 1'b1;
                        state_next      = bps_pkg::ST_CHECK;
                    end
                    else
                    begin
                        cmd.pixel_write = 1'b1;
                    end
                end
            end
            bps_pkg::ST_CHECK:
            begin
                cmd.bounds_load = 1'b1;
                cnt_next        = '0;
                state_next      = status.in_bounds ? bps_pkg::ST_READ : bps_pkg::ST_OUT;
            end
            bps_pkg::ST_READ:
            begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = bps_pkg::ST_DRAIN;
                end
            end
            bps_pkg::ST_DRAIN:
            begin
                cnt_next   = '0;
                state_next = bps_pkg::ST_HORZ;
            end
            bps_pkg::ST_HORZ:
            begin
                cmd.horz_en = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = bps_pkg::ST_VERT;
                end
            end
            bps_pkg::ST_VERT:
            begin
                cmd.vert_en = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = bps_pkg::ST_OUT;
                end
            end
            bps_pkg::ST_OUT:
            begin
                // Load the output register once it is free or being emptied.
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bps_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

// File: rtl/core/bps_datapath.sv
// ----------------------------------------------------------------------------
// Bilinear sampler datapath
// Frame store, configuration, bounds check, neighbor capture and blending.
// ----------------------------------------------------------------------------
module bps_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]           cfg_data,
    input  bps_pkg::bps_item_t                  item_payload,
    input  bps_pkg::bps_cmd_t                   cmd,
    output bps_pkg::bps_status_t                status,
    output bps_pkg::bps_result_t                result_payload
);

    // Frame store, row-major.
    logic [bps_pkg::RGB_W-1:0] store_mem [bps_pkg::STORE_DEPTH];
    logic [bps_pkg::RGB_W-1:0] mem_q_reg;
    logic [bps_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [bps_pkg::RGB_W-1:0] wr_pix;

    // Configuration.
    logic [bps_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;

    // Sample state.
    logic signed [bps_pkg::COORD_W-1:0] x_reg, y_reg;
    logic                               in_bounds_reg;
    logic                               rd_valid_reg;
    logic [1:0]                         rd_idx_reg;
    logic [bps_pkg::RGB_W-1:0]          pix_reg [4];
    logic [bps_pkg::H_W-1:0]            h0_reg [3];
    logic [bps_pkg::H_W-1:0]            h1_reg [3];
    logic [bps_pkg::PIX_W-1:0]          chan_reg [3];
    bps_pkg::bps_result_t               res_reg;

    // Bounds check signals.
    logic [bps_pkg::CFG_W-1:0] w_sat, h_sat, w_lim, h_lim;
    logic [bps_pkg::INT_W-1:0] x_int, y_int;

    // Blend signals.
    logic [bps_pkg::FRAC_BITS-1:0] dx, dy;
    logic [bps_pkg::WGT_W-1:0]     inv_dx, inv_dy;
    logic [bps_pkg::PIX_W-1:0]     a0, a1, b0, b1;
    logic [bps_pkg::H_W:0]         h0_sum, h1_sum;
    logic [bps_pkg::V_W:0]         v_sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bps_pkg::CFG_W'(bps_pkg::MAX_WIDTH);
            frame_height_reg <= bps_pkg::CFG_W'(bps_pkg::MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bps_pkg::REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_index == bps_pkg::REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // Store write port.
    assign wr_addr = {item_payload.pixel_row, item_payload.pixel_col};
    assign wr_pix  = {item_payload.pixel_red, item_payload.pixel_green,
                      item_payload.pixel_blue};

    always_ff @(posedge clk)
    begin
        if (cmd.pixel_write)
        begin
            store_mem[wr_addr] <= wr_pix;
        end
    end

    // Store read port: neighbor 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
    assign rd_addr = {y_reg[bps_pkg::FRAC_BITS +: bps_pkg::ROW_W]
                          + bps_pkg::ROW_W'(cmd.idx[1]),
                      x_reg[bps_pkg::FRAC_BITS +: bps_pkg::COL_W]
                          + bps_pkg::COL_W'(cmd.idx[0])};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mem_q_reg <= store_mem[rd_addr];
        end
    end

    // The read tag is registered alongside the store read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cmd.idx;
        if (rd_valid_reg)
        begin
            pix_reg[rd_idx_reg] <= mem_q_reg;
        end
    end

    // Coordinates are held for the whole sample.
    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
        begin
            x_reg <= item_payload.sample_x;
            y_reg <= item_payload.sample_y;
        end
    end

    // Bounds check against the saturated frame size minus one.
    always_comb
    begin
        w_sat = (frame_width_reg > bps_pkg::CFG_W'(bps_pkg::MAX_WIDTH))
              ? bps_pkg::CFG_W'(bps_pkg::MAX_WIDTH) : frame_width_reg;
        h_sat = (frame_height_reg > bps_pkg::CFG_W'(bps_pkg::MAX_HEIGHT))
              ? bps_pkg::CFG_W'(bps_pkg::MAX_HEIGHT) : frame_height_reg;
        w_lim = (w_sat == '0) ? '0 : w_sat - 1'b1;
        h_lim = (h_sat == '0) ? '0 : h_sat - 1'b1;
        x_int = x_reg[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
        y_int = y_reg[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
        status.in_bounds = !x_reg[bps_pkg::COORD_W-1] && !y_reg[bps_pkg::COORD_W-1]
                        && (x_int < bps_pkg::INT_W'(w_lim))
                        && (y_int < bps_pkg::INT_W'(h_lim));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bounds_load)
        begin
            in_bounds_reg <= status.in_bounds;
        end
    end

    // Horizontal blend of one channel for both rows.
    always_comb
    begin
        dx     = x_reg[bps_pkg::FRAC_BITS-1:0];
        dy     = y_reg[bps_pkg::FRAC_BITS-1:0];
        inv_dx = bps_pkg::WGT_W'(1 << bps_pkg::FRAC_BITS) - bps_pkg::WGT_W'(dx);
        inv_dy = bps_pkg::WGT_W'(1 << bps_pkg::FRAC_BITS) - bps_pkg::WGT_W'(dy);
        a0 = bps_pkg::chan_of(pix_reg[0], cmd.idx);
        a1 = bps_pkg::chan_of(pix_reg[1], cmd.idx);
        b0 = bps_pkg::chan_of(pix_reg[2], cmd.idx);
        b1 = bps_pkg::chan_of(pix_reg[3], cmd.idx);
        h0_sum = (bps_pkg::H_W'(a0) * bps_pkg::H_W'(inv_dx))
               + (bps_pkg::H_W'(a1) * bps_pkg::H_W'(dx));
        h1_sum = (bps_pkg::H_W'(b0) * bps_pkg::H_W'(inv_dx))
               + (bps_pkg::H_W'(b1) * bps_pkg::H_W'(dx));
    end

    // Vertical blend plus round half up.
    always_comb
    begin
        v_sum = (bps_pkg::V_W'(h0_reg[cmd.idx]) * bps_pkg::V_W'(inv_dy))
              + (bps_pkg::V_W'(h1_reg[cmd.idx]) * bps_pkg::V_W'(dy))
              + (bps_pkg::V_W'(1) << (2 * bps_pkg::FRAC_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.horz_en)
        begin
            h0_reg[cmd.idx] <= h0_sum[bps_pkg::H_W-1:0];
            h1_reg[cmd.idx] <= h1_sum[bps_pkg::H_W-1:0];
        end
        if (cmd.vert_en)
        begin
            chan_reg[cmd.idx] <= v_sum[2 * bps_pkg::FRAC_BITS +: bps_pkg::PIX_W];
        end
    end

    // Output register; rejected samples carry zero channels.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg.in_bounds <= in_bounds_reg;
            res_reg.out_blue  <= in_bounds_reg ? chan_reg[0] : '0;
            res_reg.out_green <= in_bounds_reg ? chan_reg[1] : '0;
            res_reg.out_red   <= in_bounds_reg ? chan_reg[2] : '0;
        end
    end

    assign result_payload = res_reg;

endmodule

// File: rtl/core/bilinear_pixel_sampler_unit.sv
// ----------------------------------------------------------------------------
// Bilinear pixel sampler
// 256x256 RGB frame store with a bilinear sampler on fixed-point coordinates.
//
//   Channel   Direction  Handshake      Carries
//   item      in         valid/ready    pixel write or sample request
//   result    out        valid/ready    in_bounds and blended channels
//   cfg       in         cfg_we only    frame_width, frame_height
//
// A write goes into the store and the next item is taken right after it.
// An in-bounds sample passes CHECK, READ, DRAIN, HORZ, VERT and OUT: the
// single store read port fetches the four neighbors one per cycle, then one
// shared blend unit works through the three channels horizontally and then
// vertically. A rejected sample goes from CHECK straight to OUT.
// The result waits in an output register, so writes keep flowing while it
// stalls; a finished sample waits only if that register is still full.
// Reset clears control and sets a full frame; the store has no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    bps_item_if.sink                         item,
    bps_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]        cfg_data
);

    bps_pkg::bps_cmd_t    cmd;
    bps_pkg::bps_status_t status;
    logic                 item_ready;
    logic                 result_valid;
    bps_pkg::bps_result_t result_payload;

    // Sequencer.
    bps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_command (item.payload.command),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    // Store and arithmetic.
    bps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_payload   (item.payload),
        .cmd            (cmd),
        .status         (status),
        .result_payload (result_payload)
    );

    assign item.ready     = item_ready;
    assign result.valid   = result_valid;
    assign result.payload = result_payload;

endmodule

// File: rtl/core/bps_checker.sv
// ----------------------------------------------------------------------------
// Bilinear sampler port checker
// Watches the top-level channels for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "bilinear_pixel_sampler_unit_defines.svh"

module bps_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 item_command,
    input logic                 result_valid,
    input logic                 result_ready,
    input bps_pkg::bps_result_t result_payload
);

    // A stalled result stays offered.
    `BPS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `BPS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_payload), "result payload changed while stalled")

    // A sample transfer closes the input until the sample is finished.
    `BPS_ASSERT_NEXT(a_sample_blocks, item_valid && item_ready && (item_command == bps_pkg::CMD_SAMPLE), !item_ready, "input open during a sample")

    // Rejected samples carry zero channels.
    `BPS_ASSERT_NOW(a_reject_zero, result_valid && !result_payload.in_bounds, (result_payload.out_blue == '0) && (result_payload.out_green == '0) && (result_payload.out_red == '0), "rejected sample has nonzero channels")

endmodule

bind bilinear_pixel_sampler_unit bps_checker u_bps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_command   (item.payload.command),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

// File: test/bps_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample result checker
// Watches the item, result and configuration ports of the bilinear pixel
// sampler, keeps a shadow frame store and frame size, predicts every sample
// result and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bps_sample_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    bps_item_if                           item_mon,
    bps_result_if                         result_mon,
    input  logic                          cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatch_count,
    output int                            samples_in_flight
);

    localparam int SCALE = 1 << bps_pkg::FRAC_BITS;

    // Shadow of the frame store, packed as red, green, blue from the top.
    logic [bps_pkg::RGB_W-1:0] frame_copy [bps_pkg::STORE_DEPTH];
    logic [bps_pkg::CFG_W-1:0] frame_w;
    logic [bps_pkg::CFG_W-1:0] frame_h;
    bps_pkg::bps_result_t      expected_samples [$];
    int                        errors;

    // Bilinear blend of the four neighbors, or a rejection outside the frame.
    function automatic bps_pkg::bps_result_t blend_sample(
        input logic signed [bps_pkg::COORD_W-1:0] sx,
        input logic signed [bps_pkg::COORD_W-1:0] sy);
        bps_pkg::bps_result_t      r;
        int                        x, y, w, h, x0, y0, dx, dy, base, k, h0, h1, v;
        int                        level [3];
        logic [bps_pkg::RGB_W-1:0] p00, p01, p10, p11;
        r = '0;
        x = sx;
        y = sy;
        w = (frame_w > bps_pkg::MAX_WIDTH) ? int'(bps_pkg::MAX_WIDTH) : int'(frame_w);
        h = (frame_h > bps_pkg::MAX_HEIGHT) ? int'(bps_pkg::MAX_HEIGHT) : int'(frame_h);
        if (x < 0 || y < 0 || x >= (w - 1) * SCALE || y >= (h - 1) * SCALE)
            return r;
        x0   = x >>> bps_pkg::FRAC_BITS;
        y0   = y >>> bps_pkg::FRAC_BITS;
        dx   = x & (SCALE - 1);
        dy   = y & (SCALE - 1);
        base = y0 * int'(bps_pkg::MAX_WIDTH) + x0;
        p00  = frame_copy[base];
        p01  = frame_copy[base + 1];
        p10  = frame_copy[base + int'(bps_pkg::MAX_WIDTH)];
        p11  = frame_copy[base + int'(bps_pkg::MAX_WIDTH) + 1];
        for (k = 0; k < 3; k++)
        begin
            h0 = int'(p00[bps_pkg::PIX_W*k +: bps_pkg::PIX_W]) * (SCALE - dx)
               + int'(p01[bps_pkg::PIX_W*k +: bps_pkg::PIX_W]) * dx;
            h1 = int'(p10[bps_pkg::PIX_W*k +: bps_pkg::PIX_W]) * (SCALE - dx)
               + int'(p11[bps_pkg::PIX_W*k +: bps_pkg::PIX_W]) * dx;
            v  = h0 * (SCALE - dy) + h1 * dy;
            level[k] = (v + SCALE * SCALE / 2) >> (2 * bps_pkg::FRAC_BITS);
        end
        r.in_bounds = 1'b1;
        r.out_blue  = bps_pkg::PIX_W'(level[0]);
        r.out_green = bps_pkg::PIX_W'(level[1]);
        r.out_red   = bps_pkg::PIX_W'(level[2]);
        return r;
    endfunction

    // Results are matched before new items are taken in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin : watch
        bps_pkg::bps_item_t   it;
        bps_pkg::bps_result_t got;
        bps_pkg::bps_result_t want;
        if (!rst_n)
        begin
            expected_samples.delete();
            errors  = 0;
            frame_w = bps_pkg::CFG_W'(bps_pkg::MAX_WIDTH);
            frame_h = bps_pkg::CFG_W'(bps_pkg::MAX_HEIGHT);
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                got = result_mon.payload;
                if (expected_samples.size() == 0)
                begin
                    $error("result transfer with nothing expected: in_bounds %0d, %0d/%0d/%0d",
                           got.in_bounds, got.out_blue, got.out_green, got.out_red);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.in_bounds !== want.in_bounds)
                    begin
                        $error("in_bounds: expected %0d, actual %0d",
                               want.in_bounds, got.in_bounds);
                        errors++;
                    end
                    if (got.out_blue !== want.out_blue)
                    begin
                        $error("out_blue: expected %0d, actual %0d",
                               want.out_blue, got.out_blue);
                        errors++;
                    end
                    if (got.out_green !== want.out_green)
                    begin
                        $error("out_green: expected %0d, actual %0d",
                               want.out_green, got.out_green);
                        errors++;
                    end
                    if (got.out_red !== want.out_red)
                    begin
                        $error("out_red: expected %0d, actual %0d",
                               want.out_red, got.out_red);
                        errors++;
                    end
                end
            end

            if (item_mon.valid && item_mon.ready)
            begin
                it = item_mon.payload;
                if (it.command == bps_pkg::CMD_WRITE)
                    frame_copy[int'(it.pixel_row) * int'(bps_pkg::MAX_WIDTH)
                               + int'(it.pixel_col)] =
                        {it.pixel_red, it.pixel_green, it.pixel_blue};
                else
                    expected_samples.push_back(blend_sample(it.sample_x, it.sample_y));
            end

            if (cfg_we)
            begin
                if (cfg_index == bps_pkg::REG_FRAME_WIDTH)
                    frame_w = cfg_data;
                else if (cfg_index == bps_pkg::REG_FRAME_HEIGHT)
                    frame_h = cfg_data;
            end
        end
        mismatch_count    <= errors;
        samples_in_flight <= expected_samples.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear pixel sampler testbench
// Writes pixel patches and samples inside and around them under a series of
// frame sizes and idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCALE = 1 << bps_pkg::FRAC_BITS;
    localparam int PHASES = 10;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we;
    logic [bps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bps_pkg::CFG_W-1:0]     cfg_data;

    bps_item_if   item_ch ();
    bps_result_if result_ch ();

    int mismatch_count;
    int samples_in_flight;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int holds_served;
    int sent_items;
    int cur_w;
    int cur_h;

    // Which store entries hold data, and cells whose four corners are written.
    bit pixel_written [bps_pkg::STORE_DEPTH];
    int blend_anchors [$];

    bilinear_pixel_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bps_sample_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_mon          (item_ch),
        .result_mon        (result_ch),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .samples_in_flight (samples_in_flight)
    );

    // Clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("bilinear_pixel_sampler_unit test failed");
        $finish;
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                result_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                holds_served++;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // One item transfer, after a random idle gap.
    task automatic send_item(input bps_pkg::bps_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 200)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge clk); while (!item_ch.ready);
        sent_items++;
    endtask

    function automatic bps_pkg::bps_item_t noise_item();
        bps_pkg::bps_item_t it;
        it.command     = 1'($urandom);
        it.pixel_col   = bps_pkg::COL_W'($urandom);
        it.pixel_row   = bps_pkg::ROW_W'($urandom);
        it.pixel_blue  = bps_pkg::PIX_W'($urandom);
        it.pixel_green = bps_pkg::PIX_W'($urandom);
        it.pixel_red   = bps_pkg::PIX_W'($urandom);
        it.sample_x    = bps_pkg::COORD_W'($urandom);
        it.sample_y    = bps_pkg::COORD_W'($urandom);
        return it;
    endfunction

    // Channel level with the extremes favored.
    function automatic logic [bps_pkg::PIX_W-1:0] pick_level();
        int r;
        r = $urandom_range(5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return bps_pkg::PIX_W'($urandom);
    endfunction

    function automatic int pick_frac();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 0;
        if (r == 1)
            return SCALE - 1;
        return $urandom_range(SCALE - 1);
    endfunction

    // True when the sample is rejected or all four neighbors are written.
    function automatic bit safe_to_sample(input int x, input int y);
        int base;
        if (x < 0 || y < 0 || x >= (cur_w - 1) * SCALE || y >= (cur_h - 1) * SCALE)
            return 1'b1;
        base = (y >>> bps_pkg::FRAC_BITS) * int'(bps_pkg::MAX_WIDTH)
             + (x >>> bps_pkg::FRAC_BITS);
        return pixel_written[base] && pixel_written[base + 1] &&
               pixel_written[base + int'(bps_pkg::MAX_WIDTH)] &&
               pixel_written[base + int'(bps_pkg::MAX_WIDTH) + 1];
    endfunction

    task automatic write_pixel(input int col, input int row,
                               input logic [bps_pkg::PIX_W-1:0] b,
                               input logic [bps_pkg::PIX_W-1:0] g,
                               input logic [bps_pkg::PIX_W-1:0] r);
        bps_pkg::bps_item_t it;
        it             = noise_item();
        it.command     = bps_pkg::CMD_WRITE;
        it.pixel_col   = bps_pkg::COL_W'(col);
        it.pixel_row   = bps_pkg::ROW_W'(row);
        it.pixel_blue  = b;
        it.pixel_green = g;
        it.pixel_red   = r;
        pixel_written[row * int'(bps_pkg::MAX_WIDTH) + col] = 1'b1;
        send_item(it);
    endtask

    task automatic sample_at(input int x, input int y);
        bps_pkg::bps_item_t it;
        it          = noise_item();
        it.command  = bps_pkg::CMD_SAMPLE;
        it.sample_x = bps_pkg::COORD_W'(x);
        it.sample_y = bps_pkg::COORD_W'(y);
        send_item(it);
    endtask

    // A small square of pixels, inside the frame when it fits, then its cells become anchors.
    task automatic write_patch();
        int sz, ax, ay, i, j;
        sz = $urandom_range(3, 2);
        ax = (cur_w >= sz) ? $urandom_range(cur_w - sz)
                           : $urandom_range(bps_pkg::MAX_WIDTH - sz);
        ay = (cur_h >= sz) ? $urandom_range(cur_h - sz)
                           : $urandom_range(bps_pkg::MAX_HEIGHT - sz);
        for (j = 0; j < sz; j++)
            for (i = 0; i < sz; i++)
                write_pixel(ax + i, ay + j, pick_level(), pick_level(), pick_level());
        for (j = 0; j < sz - 1; j++)
            for (i = 0; i < sz - 1; i++)
                blend_anchors.push_back((ay + j) * int'(bps_pkg::MAX_WIDTH) + ax + i);
    endtask

    // Coordinates near and far from the frame; unsafe picks are made negative.
    task automatic noise_sample();
        int x, y, tries;
        bit ok;
        ok = 1'b0;
        for (tries = 0; tries < 4 && !ok; tries++)
        begin
            if ($urandom_range(1))
            begin
                x = int'($signed(bps_pkg::COORD_W'($urandom)));
                y = int'($signed(bps_pkg::COORD_W'($urandom)));
            end
            else
            begin
                x = int'($urandom_range(cur_w * SCALE + 1023)) - 512;
                y = int'($urandom_range(cur_h * SCALE + 1023)) - 512;
            end
            ok = safe_to_sample(x, y);
        end
        if (!ok)
            x = -int'($urandom_range(524288, 1));
        sample_at(x, y);
    endtask

    // Sample inside a written cell that lies within the current frame, else a noise sample.
    task automatic anchor_sample();
        int a, x0, y0, tries;
        bit found;
        found = 1'b0;
        for (tries = 0; tries < 8 && !found && blend_anchors.size() > 0; tries++)
        begin
            a     = blend_anchors[$urandom_range(blend_anchors.size() - 1)];
            x0    = a % int'(bps_pkg::MAX_WIDTH);
            y0    = a / int'(bps_pkg::MAX_WIDTH);
            found = (x0 < cur_w - 1) && (y0 < cur_h - 1);
        end
        if (found)
            sample_at(x0 * SCALE + pick_frac(), y0 * SCALE + pick_frac());
        else
            noise_sample();
    endtask

    // Pause the sender until every sample result has been taken.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (samples_in_flight != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= bps_pkg::REG_FRAME_WIDTH;
        cfg_data  <= bps_pkg::CFG_W'(w);
        @(posedge clk);
        cfg_index <= bps_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= bps_pkg::CFG_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_w = (w > int'(bps_pkg::MAX_WIDTH)) ? int'(bps_pkg::MAX_WIDTH) : w;
        cur_h = (h > int'(bps_pkg::MAX_HEIGHT)) ? int'(bps_pkg::MAX_HEIGHT) : h;
    endtask

    // Corner cells of the full frame, exact points, rounding and every bound.
    task automatic run_directed();
        write_pixel(0, 0, 8'd0, 8'd0, 8'd0);
        write_pixel(1, 0, 8'd255, 8'd255, 8'd255);
        write_pixel(0, 1, 8'd255, 8'd0, 8'd128);
        write_pixel(1, 1, 8'd0, 8'd255, 8'd1);
        write_pixel(254, 254, 8'd255, 8'd255, 8'd255);
        write_pixel(255, 254, 8'd0, 8'd0, 8'd0);
        write_pixel(254, 255, 8'd17, 8'd200, 8'd255);
        write_pixel(255, 255, 8'd255, 8'd1, 8'd0);
        blend_anchors.push_back(0);
        blend_anchors.push_back(254 * int'(bps_pkg::MAX_WIDTH) + 254);
        sample_at(0, 0);
        sample_at(SCALE / 2, SCALE / 2);
        sample_at(SCALE - 1, SCALE - 1);
        sample_at(254 * SCALE, 254 * SCALE);
        sample_at(255 * SCALE - 1, 255 * SCALE - 1);
        sample_at(255 * SCALE, 0);
        sample_at(0, 255 * SCALE);
        sample_at(-1, 0);
        sample_at(0, -1);
        sample_at(-524288, -524288);
        sample_at(524287, 524287);
        sample_at(SCALE - 1, -524288);
    endtask

    task automatic run_random(input int n);
        int start, r;
        start = sent_items;
        while (sent_items - start < n)
        begin
            r = $urandom_range(99);
            if (r < 25)
                write_patch();
            else if (r < 35)
                write_pixel($urandom_range(255), $urandom_range(255),
                            pick_level(), pick_level(), pick_level());
            else if (r < 85)
                anchor_sample();
            else
                noise_sample();
        end
    endtask

    // Stimulus: one frame size and idle pattern per phase.
    initial
    begin
        int phase_w [PHASES];
        int phase_h [PHASES];
        int p;
        phase_w = '{256, 2, 511, 0, 1, 100, 256, 2, 0, 0};
        phase_h = '{256, 2, 511, 1, 300, 37, 2, 256, 0, 0};
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        cur_w = bps_pkg::MAX_WIDTH;
        cur_h = bps_pkg::MAX_HEIGHT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++)
        begin
            if (p >= 8)
            begin
                phase_w[p] = (p == 8) ? $urandom_range(256, 2) : $urandom_range(511);
                phase_h[p] = (p == 8) ? $urandom_range(256, 2) : $urandom_range(511);
            end
            if (p > 0)
            begin
                wait_idle();
                set_frame(phase_w[p], phase_h[p]);
            end
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 84; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 84; end
                default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
            endcase
            if (p == 0)
            begin
                run_directed();
                // Back-to-back samples against a held-off receiver fill the block.
                hold_requests++;
                repeat (12) anchor_sample();
            end
            run_random(80);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("bilinear_pixel_sampler_unit test passed");
        else
            $display("bilinear_pixel_sampler_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_item_if.sv
rtl/core/bps_result_if.sv
rtl/core/bps_ctrl.sv
rtl/core/bps_datapath.sv
rtl/core/bilinear_pixel_sampler_unit.sv
rtl/core/bps_checker.sv
test/bps_sample_checker.sv
test/testbench.sv
